// ----- hw/rtl/gmps_pkg.sv -----
`default_nettype none

package gmps_pkg;

	localparam int MAX_DIM    = 64;
	localparam int VALUE_BITS = 16;
	localparam int SUM_BITS   = 23;
	localparam int COL_BITS   = $clog2(MAX_DIM);
	localparam int DIM_BITS   = $clog2(MAX_DIM + 1);
	localparam int ADDR_BITS  = 4;

	typedef logic signed [SUM_BITS-1:0]   sum_t;
	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [COL_BITS-1:0]          col_t;
	typedef logic [DIM_BITS-1:0]          dim_t;

	localparam sum_t SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
	localparam sum_t SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		REG_GRID_ROWS = 2'd0,
		REG_GRID_COLS = 2'd1,
		REG_QUERY_ROW = 2'd2,
		REG_QUERY_COL = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic en;
		col_t addr;
		sum_t data;
	} row_wr_t;

	function automatic dim_t clamp_dim(input dim_t d);
		dim_t r;
		r = d;
		if (d == '0) begin
			r = dim_t'(1);
		end else if (d > dim_t'(MAX_DIM)) begin
			r = dim_t'(MAX_DIM);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/grid_max_path_sum_core.sv -----
// Pipeline: the row-buffer read at transfer loads the stage-1 register, and
// the add-and-saturate stage after it loads the output register.
// Throughput: one cell per cycle unless m_axis_tready holds the output full.
// Reset: arst_n clears position, left sum, pipeline valids and the registers
// to rows 5, cols 5, query (4,4); the row buffer is not cleared.
`default_nettype none

module grid_max_path_sum_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [gmps_pkg::ADDR_BITS-1:0] paddr,
	input  wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [15:0] s_axis_tdata,   // [15:0] cell_value
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [22:0] path_sum, [23] zero
	output logic [0:0] m_axis_tuser,   // [0] is_query_cell
	output logic       m_axis_tlast    // grid_done
);
	import gmps_pkg::*;

	dim_t rows_q, cols_q;
	col_t qrow_q, qcol_q;
	col_t row_q, col_q;
	sum_t left_q;

	logic     valid_s1, top_s1, query_s1, done_s1;
	col_t     col_s1;
	value_t   val_s1;
	sum_t     up_s1;

	logic     out_valid_q, out_query_q, out_done_q;
	sum_t     out_sum_q;

	logic     cfg_wr, in_acc, adv_s1, last_col, last_row;
	dim_t     rows_eff, cols_eff;
	reg_idx_t reg_idx;
	sum_t     best, sum_sat;
	logic signed [SUM_BITS:0] sum_wide;
	row_wr_t  wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= dim_t'(5);
			cols_q <= dim_t'(5);
			qrow_q <= col_t'(4);
			qcol_q <= col_t'(4);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_GRID_ROWS: rows_q <= pwdata[DIM_BITS-1:0];
				REG_GRID_COLS: cols_q <= pwdata[DIM_BITS-1:0];
				REG_QUERY_ROW: qrow_q <= pwdata[COL_BITS-1:0];
				REG_QUERY_COL: qcol_q <= pwdata[COL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GRID_ROWS: prdata = 32'(rows_q);
			REG_GRID_COLS: prdata = 32'(cols_q);
			REG_QUERY_ROW: prdata = 32'(qrow_q);
			REG_QUERY_COL: prdata = 32'(qcol_q);
			default:       prdata = '0;
		endcase
	end

	assign rows_eff = clamp_dim(rows_q);
	assign cols_eff = clamp_dim(cols_q);
	assign last_col = {1'b0, col_q} >= (cols_eff - dim_t'(1));
	assign last_row = {1'b0, row_q} >= (rows_eff - dim_t'(1));

	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + col_t'(1);
			end else begin
				col_q <= col_q + col_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			val_s1   <= s_axis_tdata[VALUE_BITS-1:0];
			col_s1   <= col_q;
			top_s1   <= (row_q == '0);
			query_s1 <= (row_q == qrow_q) && (col_q == qcol_q);
			done_s1  <= last_col && last_row;
		end
	end

	assign wr.en   = adv_s1;
	assign wr.addr = col_s1;
	assign wr.data = sum_sat;

	gmps_row_chain u_row (
		.clk       (clk),
		.wr        (wr),
		.rd_en     (in_acc),
		.rd_addr   (col_q),
		.rd_data_q (up_s1)
	);

	always_comb begin
		if (top_s1) begin
			best = (col_s1 == '0) ? '0 : left_q;
		end else if (col_s1 == '0) begin
			best = up_s1;
		end else begin
			best = (up_s1 > left_q) ? up_s1 : left_q;
		end
		sum_wide = (SUM_BITS+1)'(best) + (SUM_BITS+1)'(val_s1);
		if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
			sum_sat = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_wide[SUM_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			left_q      <= sum_sat;
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_sum_q   <= sum_sat;
			out_query_q <= query_s1;
			out_done_q  <= done_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_sum_q};
	assign m_axis_tuser  = out_query_q;
	assign m_axis_tlast  = out_done_q;

`ifndef NO_ASSERTIONS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled while output register empty");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while pipeline is full and stalled");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_col && last_row) |=> (row_q == '0 && col_q == '0))
		else $error("position did not wrap after last cell");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/gmps_row_cell.sv -----
`default_nettype none

module gmps_row_cell (
	input  wire                   clk,
	input  wire gmps_pkg::col_t   idx,
	input  wire gmps_pkg::row_wr_t wr,
	input  wire gmps_pkg::col_t   rd_addr,
	input  wire gmps_pkg::sum_t   link_in,
	output gmps_pkg::sum_t        link_out
);
	import gmps_pkg::*;

	sum_t val_q;

	always_ff @(posedge clk) begin
		if (wr.en && (wr.addr == idx)) begin
			val_q <= wr.data;
		end
	end

	assign link_out = link_in | ((rd_addr == idx) ? val_q : '0);

endmodule

`default_nettype wire

// ----- hw/rtl/gmps_row_chain.sv -----
`default_nettype none

module gmps_row_chain (
	input  wire                    clk,
	input  wire gmps_pkg::row_wr_t wr,
	input  wire                    rd_en,
	input  wire gmps_pkg::col_t    rd_addr,
	output gmps_pkg::sum_t         rd_data_q
);
	import gmps_pkg::*;

	sum_t link [MAX_DIM+1];

	assign link[0] = '0;

	for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
		gmps_row_cell u_cell (
			.clk      (clk),
			.idx      (col_t'(k)),
			.wr       (wr),
			.rd_addr  (rd_addr),
			.link_in  (link[k]),
			.link_out (link[k+1])
		);
	end

	// forward a same-column write landing on this edge
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && (wr.addr == rd_addr)) begin
				rd_data_q <= wr.data;
			end else begin
				rd_data_q <= link[MAX_DIM];
			end
		end
	end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import gmps_pkg::*;

	localparam int RANDOM_CELLS = 600;
	localparam int STALL_LIMIT  = 2000;

	typedef struct packed {
		sum_t sum;
		logic query;
		logic done;
	} cell_result_t;

	typedef struct {
		logic         fixed;
		cell_result_t res;
	} fixed_result_t;

	typedef struct {
		logic         is_cfg;
		reg_idx_t     idx;
		logic [31:0]  wdata;
		value_t       cell_val;
		logic         fixed;
		cell_result_t res;
	} plan_row_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 psel          = 1'b0;
	logic                 penable       = 1'b0;
	logic                 pwrite        = 1'b0;
	logic [ADDR_BITS-1:0] paddr         = '0;
	logic [31:0]          pwdata        = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata  = '0;   // [15:0] cell_value
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;         // [22:0] path_sum, [23] zero
	logic [0:0]           m_axis_tuser;         // [0] is_query_cell
	logic                 m_axis_tlast;

	grid_max_path_sum_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [6:0] rows_cfg = 7'd5;
	logic [6:0] cols_cfg = 7'd5;
	logic [5:0] qrow_cfg = 6'd4;
	logic [5:0] qcol_cfg = 6'd4;
	sum_t       row_sums [MAX_DIM];
	logic       row_seen [MAX_DIM];
	sum_t       left_sum = '0;
	int         row_pos  = 0;
	int         col_pos  = 0;

	cell_result_t  pending_sums [$];
	fixed_result_t fixed_sums   [$];
	plan_row_t     plan         [$];

	int  errors       = 0;
	int  cells_sent   = 0;
	int  results_seen = 0;
	int  query_hits   = 0;
	int  grids_done   = 0;
	int  cfg_writes   = 0;
	int  idle_cycles  = 0;
	logic no_idle     = 1'b0;

	initial begin
		for (int i = 0; i < MAX_DIM; i++) begin
			row_seen[i] = 1'b0;
			row_sums[i] = '0;
		end
	end

	function automatic int dim_eff(logic [6:0] d);
		if (d == 7'd0) return 1;
		if (d > 7'(MAX_DIM)) return MAX_DIM;
		return int'(d);
	endfunction

	function automatic cell_result_t next_path_sum(value_t v);
		cell_result_t r;
		longint acc;
		longint up;
		int rows_n;
		int cols_n;
		rows_n = dim_eff(rows_cfg);
		cols_n = dim_eff(cols_cfg);
		if (row_pos == 0) begin
			acc = (col_pos == 0) ? longint'(v) : longint'(left_sum) + longint'(v);
		end else begin
			up = longint'(row_sums[col_pos]);
			if (col_pos != 0 && longint'(left_sum) > up) up = longint'(left_sum);
			acc = up + longint'(v);
		end
		if (acc > longint'(SUM_MAX)) acc = longint'(SUM_MAX);
		else if (acc < longint'(SUM_MIN)) acc = longint'(SUM_MIN);
		r.sum = sum_t'(acc);
		row_sums[col_pos] = r.sum;
		row_seen[col_pos] = 1'b1;
		left_sum = r.sum;
		r.query = (row_pos == int'(qrow_cfg)) && (col_pos == int'(qcol_cfg));
		r.done  = (col_pos >= cols_n - 1) && (row_pos >= rows_n - 1);
		if (col_pos >= cols_n - 1) begin
			col_pos = 0;
			row_pos = (row_pos >= rows_n - 1) ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		return r;
	endfunction

	// a new column count must not make a later row read a sum never written
	function automatic logic cols_safe(logic [6:0] c);
		int top;
		if (row_pos == 0) return 1'b1;
		top = dim_eff(c) - 1;
		if (col_pos > top) top = col_pos;
		for (int i = 0; i <= top; i++) begin
			if (!row_seen[i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] MISMATCH %s: got %0d expected %0d (result %0d)",
			$time, what, got, want, results_seen);
		errors++;
	endtask

	always @(posedge clk) begin : monitor
		cell_result_t want;
		fixed_result_t f;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				want = next_path_sum(value_t'(s_axis_tdata));
				if (fixed_sums.size() != 0) begin
					f = fixed_sums.pop_front();
					if (f.fixed) want = f.res;
				end
				pending_sums.insert(pending_sums.size(), want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_sums.size() == 0) begin
					report_mismatch("result with nothing pending", m_axis_tdata, 0);
				end else begin
					want = pending_sums.pop_front();
					if (m_axis_tdata !== {1'b0, want.sum})
						report_mismatch("path_sum", sum_t'(m_axis_tdata[22:0]), want.sum);
					if (m_axis_tuser[0] !== want.query)
						report_mismatch("is_query_cell", m_axis_tuser[0], want.query);
					if (m_axis_tlast !== want.done)
						report_mismatch("grid_done", m_axis_tlast, want.done);
					if (want.query) query_hits++;
					if (want.done) grids_done++;
				end
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[%0t] watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : sink
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 9);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_cell(value_t v, logic fixed, cell_result_t res);
		int gap;
		fixed_result_t f;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		f.fixed = fixed;
		f.res   = res;
		fixed_sums.insert(fixed_sums.size(), f);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		do @(posedge clk); while (!s_axis_tready);
		cells_sent++;
	endtask

	// drop valid and wait until every pending result has arrived
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_sums.size() != 0);
	endtask

	task automatic program_reg(reg_idx_t idx, logic [31:0] wdata);
		logic [31:0] stored;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_GRID_ROWS: begin
				rows_cfg = wdata[6:0];
				stored   = 32'(wdata[6:0]);
			end
			REG_GRID_COLS: begin
				cols_cfg = wdata[6:0];
				stored   = 32'(wdata[6:0]);
			end
			REG_QUERY_ROW: begin
				qrow_cfg = wdata[5:0];
				stored   = 32'(wdata[5:0]);
			end
			default: begin
				qcol_cfg = wdata[5:0];
				stored   = 32'(wdata[5:0]);
			end
		endcase
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== stored) report_mismatch("register readback", prdata, stored);
		psel    <= 1'b0;
		penable <= 1'b0;
		cfg_writes++;
	endtask

	function automatic plan_row_t cfg_row(reg_idx_t idx, logic [31:0] wdata);
		plan_row_t p;
		p.is_cfg   = 1'b1;
		p.idx      = idx;
		p.wdata    = wdata;
		p.cell_val = '0;
		p.fixed    = 1'b0;
		p.res      = '0;
		return p;
	endfunction

	function automatic plan_row_t cell_row(value_t v, logic fixed, sum_t s, logic q, logic d);
		plan_row_t p;
		p.is_cfg    = 1'b0;
		p.idx       = REG_GRID_ROWS;
		p.wdata     = '0;
		p.cell_val  = v;
		p.fixed     = fixed;
		p.res.sum   = s;
		p.res.query = q;
		p.res.done  = d;
		return p;
	endfunction

	function automatic void add_row(plan_row_t r);
		plan.insert(plan.size(), r);
	endfunction

	function automatic value_t pick_cell();
		case ($urandom_range(0, 9))
			0:       return value_t'(16'sh7FFF);
			1:       return value_t'(16'sh8000);
			2:       return value_t'($urandom_range(0, 15) - 8);
			default: return value_t'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [6:0] pick_dim();
		case ($urandom_range(0, 19))
			0:       return 7'd0;
			1:       return 7'd64;
			2:       return 7'($urandom_range(65, 127));
			3:       return 7'd1;
			4:       return 7'($urandom_range(9, 64));
			default: return 7'($urandom_range(2, 8));
		endcase
	endfunction

	function automatic logic [5:0] pick_query(int dim);
		case ($urandom_range(0, 5))
			0:       return 6'd0;
			1:       return 6'd63;
			2:       return 6'($urandom_range(0, 63));
			default: return 6'($urandom_range(0, dim - 1));
		endcase
	endfunction

	initial begin : stimulus
		plan_row_t p;
		logic [6:0] d;
		int burst;
		int random_sent;

		// single-row grid, three columns: sums are running totals along the row
		add_row(cfg_row(REG_GRID_ROWS, 32'hFFFF_FF80));
		add_row(cfg_row(REG_GRID_COLS, 32'd3));
		add_row(cfg_row(REG_QUERY_ROW, 32'd0));
		add_row(cfg_row(REG_QUERY_COL, 32'hA5A5_A5C2));
		add_row(cell_row(16'sh7FFF, 1'b1, 23'sd32767, 1'b0, 1'b0));
		add_row(cell_row(16'sh7FFF, 1'b1, 23'sd65534, 1'b0, 1'b0));
		add_row(cell_row(16'sh8000, 1'b1, 23'sd32766, 1'b1, 1'b1));
		add_row(cell_row(16'sh8000, 1'b1, -23'sd32768, 1'b0, 1'b0));
		add_row(cell_row(-16'sd1, 1'b1, -23'sd32769, 1'b0, 1'b0));
		add_row(cell_row(16'sd0, 1'b1, -23'sd32769, 1'b1, 1'b1));
		// single column, oversized row count
		add_row(cfg_row(REG_GRID_ROWS, 32'd127));
		add_row(cfg_row(REG_GRID_COLS, 32'd0));
		add_row(cfg_row(REG_QUERY_ROW, 32'd63));
		add_row(cfg_row(REG_QUERY_COL, 32'd0));
		add_row(cell_row(16'sh7FFF, 1'b1, 23'sd32767, 1'b0, 1'b0));
		add_row(cell_row(16'sh7FFF, 1'b0, '0, 1'b0, 1'b0));
		add_row(cell_row(16'sh7FFF, 1'b0, '0, 1'b0, 1'b0));
		add_row(cell_row(16'sh8000, 1'b0, '0, 1'b0, 1'b0));
		add_row(cell_row(16'sd12345, 1'b0, '0, 1'b0, 1'b0));
		// shrink rows mid-grid: position beyond the new last row wraps
		add_row(cfg_row(REG_GRID_ROWS, 32'd2));
		add_row(cfg_row(REG_QUERY_ROW, 32'd5));
		add_row(cell_row(-16'sd7, 1'b0, '0, 1'b0, 1'b0));
		// 2x2 with the query cell outside the grid
		add_row(cfg_row(REG_GRID_COLS, 32'd2));
		add_row(cfg_row(REG_QUERY_ROW, 32'd40));
		add_row(cfg_row(REG_QUERY_COL, 32'd63));
		add_row(cell_row(16'sd100, 1'b0, '0, 1'b0, 1'b0));
		add_row(cell_row(-16'sd300, 1'b0, '0, 1'b0, 1'b0));
		add_row(cell_row(16'sd50, 1'b0, '0, 1'b0, 1'b0));
		add_row(cell_row(16'sh8000, 1'b0, '0, 1'b0, 1'b0));
		// 3x3 with an inner query cell
		add_row(cfg_row(REG_GRID_ROWS, 32'd3));
		add_row(cfg_row(REG_GRID_COLS, 32'd3));
		add_row(cfg_row(REG_QUERY_ROW, 32'd1));
		add_row(cfg_row(REG_QUERY_COL, 32'd1));
		for (int i = 0; i < 9; i++) begin
			add_row(cell_row(value_t'((i * 7919) ^ 16'h5A5A), 1'b0, '0, 1'b0, 1'b0));
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			p = plan[i];
			if (p.is_cfg) begin
				settle();
				program_reg(p.idx, p.wdata);
			end else begin
				send_cell(p.cell_val, p.fixed, p.res);
			end
		end

		random_sent = 0;
		while (random_sent < RANDOM_CELLS) begin
			settle();
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) != 0) begin
				d = pick_dim();
				program_reg(REG_GRID_ROWS, ($urandom() & 32'hFFFF_FF80) | 32'(d));
			end
			d = pick_dim();
			if ($urandom_range(0, 2) != 0 && cols_safe(d))
				program_reg(REG_GRID_COLS, ($urandom() & 32'hFFFF_FF80) | 32'(d));
			if ($urandom_range(0, 1) != 0)
				program_reg(REG_QUERY_ROW, ($urandom() & 32'hFFFF_FFC0) |
					32'(pick_query(dim_eff(rows_cfg))));
			if ($urandom_range(0, 1) != 0)
				program_reg(REG_QUERY_COL, ($urandom() & 32'hFFFF_FFC0) |
					32'(pick_query(dim_eff(cols_cfg))));
			burst = $urandom_range(1, 60);
			for (int i = 0; i < burst; i++) begin
				send_cell(pick_cell(), 1'b0, '0);
				random_sent++;
			end
		end

		settle();
		repeat (6) @(posedge clk);
		$display("Run covered %0d cells and %0d results over %0d register writes",
			cells_sent, results_seen, cfg_writes);
		$display("Query cell flagged %0d times, %0d grids completed",
			query_hits, grids_done);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/gmps_pkg.sv
hw/rtl/gmps_row_cell.sv
hw/rtl/gmps_row_chain.sv
hw/rtl/grid_max_path_sum_core.sv
dv/tb_top.sv
